### rtl/core/move_to_front_weighted_cost_top_macros.svh
// Assertion macros shared by the weighted move-to-front checker
`ifndef MOVE_TO_FRONT_WEIGHTED_COST_TOP_MACROS_SVH
`define MOVE_TO_FRONT_WEIGHTED_COST_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define MTFWC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define MTFWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mtfwc_pkg.sv
// Shared widths, codes and types of the weighted move-to-front block
package mtfwc_pkg;

    localparam int ID_W     = 6;
    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 22;
    localparam int TOTAL_W  = 32;
    localparam int NUM_IDS  = 1 << ID_W;

    localparam logic OP_SET    = 1'b0;
    localparam logic OP_ACCESS = 1'b1;

    // One stack entry as held in a cell and handed to the next one down
    typedef struct packed {
        logic                valid;
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
    } ent_t;

    // Commands broadcast to every cell
    typedef struct packed {
        logic                move;
        logic                wr_weight;
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] wv;
    } ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

### rtl/core/mtfwc_ram.sv
// Generic single-write, single-read RAM with registered read data
module mtfwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/mtfwc_cell.sv
// One stack cell: holds an entry, matches the requested id, shifts down on a move
module mtfwc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  mtfwc_pkg::ctl_t   ctl,
    input  mtfwc_pkg::ent_t   up,
    input  logic              above,
    output mtfwc_pkg::ent_t   ent,
    output logic              match
);

    logic                           valid_reg;
    logic [mtfwc_pkg::ID_W-1:0]     id_reg;
    logic [mtfwc_pkg::WEIGHT_W-1:0] weight_reg;
    logic                           take;

    assign match = valid_reg && (id_reg == ctl.id);
    // take the upper neighbour's entry when the hit lies at or below this cell
    assign take  = ctl.move && !above && up.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            id_reg     <= up.id;
            weight_reg <= up.weight;
        end
        else if (ctl.wr_weight && match)
        begin
            weight_reg <= ctl.wv;
        end
    end

    assign ent = {valid_reg, id_reg, weight_reg};

endmodule

### rtl/core/move_to_front_weighted_cost_top.sv
// Weighted move-to-front stack: a chain of cells, a registered prefix-sum tree and a weight RAM.
// One item is worked at a time, in steps: the cell matches are registered, the weights above
// the hit are summed through each level of the registered adder tree, the move and the result
// are committed once the output register is empty or being read, and the block returns to idle.
// The result sits in an output register, so the next item can be taken while it waits. A set
// item stores the weight in the weight RAM and in any cell holding that id and yields a zero
// cost; ids at or above NUM_ITEMS are ignored. The running total saturates at all ones. The
// stack and the weight store start empty after reset.
module move_to_front_weighted_cost_top #(
    parameter int NUM_ITEMS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic [mtfwc_pkg::ID_W-1:0]      item_id,
    input  logic [mtfwc_pkg::WEIGHT_W-1:0]  weight_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mtfwc_pkg::COST_W-1:0]    access_cost,
    output logic [mtfwc_pkg::TOTAL_W-1:0]   running_total
);

    localparam int ID_W      = mtfwc_pkg::ID_W;
    localparam int WEIGHT_W  = mtfwc_pkg::WEIGHT_W;
    localparam int COST_W    = mtfwc_pkg::COST_W;
    localparam int TOTAL_W   = mtfwc_pkg::TOTAL_W;
    localparam int LEV       = $clog2(NUM_ITEMS);
    localparam int P         = 1 << LEV;
    localparam int SUM_W     = WEIGHT_W + LEV;
    localparam int TBL_DEPTH = (NUM_ITEMS < mtfwc_pkg::NUM_IDS) ? NUM_ITEMS
                                                               : mtfwc_pkg::NUM_IDS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int CNT_W     = $clog2(LEV + 1);

    mtfwc_pkg::state_t state_reg, state_next;

    logic                 op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [WEIGHT_W-1:0]  wv_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 out_valid_reg;
    logic [COST_W-1:0]    access_cost_reg;
    logic [TOTAL_W-1:0]   total_reg;

    logic [TBL_DEPTH-1:0] tbl_valid_reg;
    logic [TBL_AW-1:0]    tbl_idx;
    logic [WEIGHT_W-1:0]  tbl_rdata;

    logic                 in_range;
    logic                 commit;
    mtfwc_pkg::ctl_t      ctl;
    mtfwc_pkg::ent_t      new_ent;
    mtfwc_pkg::ent_t      ent  [NUM_ITEMS];
    mtfwc_pkg::ent_t      feed [NUM_ITEMS];
    logic                 match [NUM_ITEMS];

    // heap-ordered tree: node 1 is the root, leaves sit at P .. 2P-1
    logic [SUM_W-1:0]     sum_reg   [1:2*P-1];
    logic                 found_reg [1:2*P-1];
    logic                 above_arr [1:2*P-1];

    logic [COST_W-1:0]    cost;
    logic [TOTAL_W:0]     sum_ext;
    logic [TOTAL_W-1:0]   total_next;

    // ---------------------------------------------------------------- control
    assign in_ready = (state_reg == mtfwc_pkg::ST_IDLE);
    assign commit   = (state_reg == mtfwc_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign in_range = (32'(id_reg) < 32'(NUM_ITEMS));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            mtfwc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mtfwc_pkg::ST_LOOK;
                end
            end
            mtfwc_pkg::ST_LOOK:
            begin
                cnt_next   = '0;
                state_next = mtfwc_pkg::ST_SUM;
            end
            mtfwc_pkg::ST_SUM:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(LEV - 1))
                begin
                    state_next = mtfwc_pkg::ST_DONE;
                end
            end
            mtfwc_pkg::ST_DONE:
            begin
                if (commit)
                begin
                    state_next = mtfwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtfwc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtfwc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            tbl_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ctl.wr_weight)
            begin
                tbl_valid_reg[tbl_idx] <= 1'b1;
            end
        end
    end

    // hold the item for the whole of its work
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= operation;
            id_reg <= item_id;
            wv_reg <= weight_value;
        end
        if (commit)
        begin
            access_cost_reg <= cost;
        end
    end

    always_comb
    begin
        ctl.move      = commit && (op_reg == mtfwc_pkg::OP_ACCESS) && in_range;
        ctl.wr_weight = commit && (op_reg == mtfwc_pkg::OP_SET) && in_range;
        ctl.id        = id_reg;
        ctl.wv        = wv_reg;
    end

    // ------------------------------------------------------------ weight store
    assign tbl_idx = id_reg[TBL_AW-1:0];

    mtfwc_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .clk   (clk),
        .we    (ctl.wr_weight),
        .waddr (tbl_idx),
        .wdata (wv_reg),
        .raddr (tbl_idx),
        .rdata (tbl_rdata)
    );

    always_comb
    begin
        new_ent.valid  = 1'b1;
        new_ent.id     = id_reg;
        new_ent.weight = tbl_valid_reg[tbl_idx] ? tbl_rdata : '0;
    end

    // ------------------------------------------------------------ cell chain
    for (genvar k = 0; k < NUM_ITEMS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_top
            assign feed[k] = new_ent;
        end
        else
        begin : g_rest
            assign feed[k] = ent[k-1];
        end

        mtfwc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .up    (feed[k]),
            .above (above_arr[P+k]),
            .ent   (ent[k]),
            .match (match[k])
        );

        // leaf: weight counts only for a valid entry that is not the hit
        always_ff @(posedge clk)
        begin
            found_reg[P+k] <= match[k];
            sum_reg[P+k]   <= (ent[k].valid && !match[k]) ? SUM_W'(ent[k].weight) : '0;
        end
    end

    for (genvar k = NUM_ITEMS; k < P; k++)
    begin : g_pad
        always_ff @(posedge clk)
        begin
            found_reg[P+k] <= 1'b0;
            sum_reg[P+k]   <= '0;
        end
    end

    // ------------------------------------------------ prefix sum up to the hit
    for (genvar n = 1; n < P; n++)
    begin : g_node
        // drop the lower half once the hit lies in the upper half
        always_ff @(posedge clk)
        begin
            found_reg[n] <= found_reg[2*n] || found_reg[2*n+1];
            sum_reg[n]   <= found_reg[2*n] ? sum_reg[2*n] : sum_reg[2*n] + sum_reg[2*n+1];
        end

        // a hit strictly above: inherited, or in the upper sibling
        assign above_arr[2*n]   = above_arr[n];
        assign above_arr[2*n+1] = above_arr[n] || found_reg[2*n];
    end

    assign above_arr[1] = 1'b0;

    // ----------------------------------------------------------------- result
    assign cost       = ((op_reg == mtfwc_pkg::OP_ACCESS) && in_range) ? COST_W'(sum_reg[1])
                                                                       : '0;
    assign sum_ext    = {1'b0, total_reg} + (TOTAL_W + 1)'(cost);
    assign total_next = sum_ext[TOTAL_W] ? '1 : sum_ext[TOTAL_W-1:0];

    assign out_valid     = out_valid_reg;
    assign access_cost   = access_cost_reg;
    assign running_total = total_reg;

endmodule

### rtl/core/mtfwc_checker.sv
// Port-level checks of the weighted move-to-front block, bound to the top level
`include "move_to_front_weighted_cost_top_macros.svh"

module mtfwc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [mtfwc_pkg::COST_W-1:0]    access_cost,
    input logic [mtfwc_pkg::TOTAL_W-1:0]   running_total
);

    `MTFWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(access_cost) && $stable(running_total), "stalled result dropped or changed")
    `MTFWC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "second input taken while an item is in flight")
    `MTFWC_ASSERT_NOW(a_out_after_work, $rose(out_valid), $past(!in_ready), "result appeared without work in progress")
    `MTFWC_ASSERT_NOW(a_total_covers_cost, out_valid, running_total >= 32'(access_cost), "running total below the cost it includes")

endmodule

bind move_to_front_weighted_cost_top mtfwc_checker u_mtfwc_checker (.*);
